@@ design/lltc_pkg.sv @@
`default_nettype none

package lltc_pkg;

   // Line timing thresholds in machine cycles.
   localparam int unsigned COUNT_W = 10;
   localparam int unsigned LINE_W  = 8;

   localparam logic [COUNT_W-1:0] OAM_END   = 10'd80;
   localparam logic [COUNT_W-1:0] DRAW_END  = 10'd252;
   localparam logic [COUNT_W-1:0] LINE_END  = 10'd456;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

   localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = 8'd144;
   localparam logic [LINE_W-1:0] LAST_LINE         = 8'd153;

   // Mode codes as seen by software.
   localparam logic [1:0] MODE_CODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_CODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_CODE_OAM    = 2'd2;
   localparam logic [1:0] MODE_CODE_DRAW   = 2'd3;

   // Register indexes on the control port.
   localparam logic [1:0] CSR_DISPLAY_ENABLE = 2'd0;
   localparam logic [1:0] CSR_LINE_COMPARE   = 2'd1;
   localparam logic [1:0] CSR_STATUS_ENABLES = 2'd2;

   // One-hot display mode state.
   typedef enum logic [3:0] {
      MODE_HBLANK = 4'b0001,
      MODE_VBLANK = 4'b0010,
      MODE_OAM    = 4'b0100,
      MODE_DRAW   = 4'b1000
   } mode_type;

   typedef struct packed {
      logic             display_enable;
      logic [7:0]       line_compare;
      logic [3:0]       status_enables;
   } cfg_type;

   typedef struct packed {
      logic [6:0]       status_byte;
      logic             render_line;
      logic [1:0]       display_mode;
      logic [LINE_W-1:0] line_number;
   } result_type;

endpackage

`default_nettype wire

@@ design/lltc_timing_core.sv @@
`default_nettype none

module lltc_timing_core
   import lltc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic [7:0]  elapsed_cycles,
   input  wire cfg_type     cfg,
   output result_type       result
);

   mode_type             mode_ff, mode_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [LINE_W-1:0]    line_ff, line_in;
   logic [COUNT_W:0]     sum;
   logic [COUNT_W-1:0]   count_sat;
   logic [LINE_W-1:0]    line_inc;
   logic                 render;
   logic [1:0]           mode_code;

   // Add the elapsed cycles, saturating at the counter's top value.
   assign sum       = {1'b0, count_ff} + {3'b000, elapsed_cycles};
   assign count_sat = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
   assign line_inc  = line_ff + 8'd1;

   // Next state: at most one mode transition per step.
   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      line_in  = line_ff;
      render   = 1'b0;
      if (cfg.display_enable) begin
         count_in = count_sat;
         case (mode_ff)
            MODE_OAM: begin
               if (count_sat >= OAM_END) mode_in = MODE_DRAW;
            end
            MODE_DRAW: begin
               if (count_sat >= DRAW_END) begin
                  mode_in = MODE_HBLANK;
                  render  = 1'b1;
               end
            end
            MODE_HBLANK: begin
               if (count_sat >= LINE_END) begin
                  line_in  = line_inc;
                  count_in = '0;
                  mode_in  = (line_inc < FIRST_VBLANK_LINE) ? MODE_OAM : MODE_VBLANK;
               end
            end
            MODE_VBLANK: begin
               if (count_sat >= LINE_END) begin
                  count_in = '0;
                  if (line_inc > LAST_LINE) begin
                     line_in = '0;
                     mode_in = MODE_OAM;
                  end else begin
                     line_in = line_inc;
                  end
               end
            end
            default: begin
               mode_in = MODE_OAM;
            end
         endcase
      end
   end

   // Encode the one-hot state into the software mode code.
   always_comb begin
      case (mode_in)
         MODE_HBLANK: mode_code = MODE_CODE_HBLANK;
         MODE_VBLANK: mode_code = MODE_CODE_VBLANK;
         MODE_OAM:    mode_code = MODE_CODE_OAM;
         MODE_DRAW:   mode_code = MODE_CODE_DRAW;
         default:     mode_code = MODE_CODE_OAM;
      endcase
   end

   // Result reflects the state after this step.
   always_comb begin
      result.line_number  = line_in;
      result.display_mode = mode_code;
      result.render_line  = render;
      result.status_byte  = {cfg.status_enables, (line_in == cfg.line_compare), mode_code};
   end

   // State registers advance once per step.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_OAM;
         count_ff <= '0;
         line_ff  <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         line_ff  <= line_in;
      end
   end

   // The line counter never runs past the last vertical blank line.
   a_line_range: assert property (@(posedge clock) disable iff (reset)
      line_ff <= LAST_LINE)
      else $error("line counter beyond last line");

   // A disabled display holds all timing state across a step.
   a_frozen: assert property (@(posedge clock) disable iff (reset)
      step && !cfg.display_enable |=> $stable(line_ff) && $stable(mode_ff)
      && $stable(count_ff))
      else $error("timing state changed while display disabled");

   // A render pulse only comes from leaving drawing into horizontal blank.
   a_render: assert property (@(posedge clock) disable iff (reset)
      step && render |=> mode_ff == MODE_HBLANK && $past(mode_ff) == MODE_DRAW)
      else $error("render pulse without drawing end");

   // Vertical blank is only ever seen on lines 144 to 153.
   a_vblank_lines: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_VBLANK |-> line_ff >= FIRST_VBLANK_LINE)
      else $error("vertical blank on a visible line");

endmodule

`default_nettype wire

@@ design/lcd_line_timing_controller_unit.sv @@
// LCD line timing controller.
// Each beat on the req_ channel carries the machine cycles elapsed since the
// previous beat. While the display is enabled the block advances its line
// cycle counter and steps through OAM scan, drawing, horizontal blank and
// vertical blank, and returns one beat on the rsp_ channel per request with
// the line number, the mode, a render pulse and the status byte.
// Registers are written through the csr_ channel, which is always ready;
// write them only while no request is in flight.
// A request beat is captured in the input register and the result in the
// result register. Throughput is one beat per cycle while the receiver
// keeps up, set by the single add and compare path between those registers.
// When the receiver stalls, the result holds and the input register keeps
// accepting until both stages are full, then req_tready drops.
// Reset clears both stages and the registers, and starts at line 0 in OAM scan.
`default_nettype none

module lcd_line_timing_controller_unit
   import lltc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] elapsed_cycles
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] line_number, [9:8] display_mode,
                                         // [10] render_line, [17:11] status_byte
   // Register write channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   logic        in_valid_ff;
   logic [7:0]  in_cycles_ff;
   logic        out_valid_ff;
   result_type  out_ff;
   cfg_type     cfg_ff;
   result_type  result;
   logic        out_free;
   logic        step;

   // Output stage can take a new beat when empty or being drained.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign csr_ready  = 1'b1;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cycles_ff <= req_tdata;
      end
   end

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DISPLAY_ENABLE: cfg_ff.display_enable <= csr_data[0];
            CSR_LINE_COMPARE:   cfg_ff.line_compare   <= csr_data;
            CSR_STATUS_ENABLES: cfg_ff.status_enables <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   lltc_timing_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .elapsed_cycles (in_cycles_ff),
      .cfg            (cfg_ff),
      .result         (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b000000, out_ff};

endmodule

`default_nettype wire

@@ bench/lcd_line_timing_controller_unit_tb.sv @@
`default_nettype none

module lcd_line_timing_controller_unit_tb
   import lltc_pkg::*;
;

   // The control port has four index codes; the last one maps to no register.
   localparam logic [1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int BLOCK_ITEMS = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;      // [7:0] elapsed_cycles
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;             // [7:0] line_number, [9:8] display_mode,
                                       // [10] render_line, [17:11] status_byte
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [7:0]  csr_data = 8'd0;

   lcd_line_timing_controller_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // Shadow copy of the registers and of the timing state.
   cfg_type      shadow_cfg = '0;
   logic [1:0]   scan_mode = MODE_CODE_OAM;
   logic [9:0]   cycle_tally = '0;
   logic [7:0]   scan_line = '0;

   logic [7:0]   pending_cycles [$];
   result_type   expected_timing [$];
   result_type   got_beat;
   result_type   want_beat;

   int send_idle_pct = 8;
   int recv_idle_pct = 83;
   int hold_trigger = 0;
   int hold_served = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   int mismatches = 0;
   int beats_sent = 0;
   int results_seen = 0;
   int render_pulses = 0;
   int vblank_results = 0;
   int compare_hits = 0;
   int frame_wraps = 0;

   // Advance the line timing by one beat of elapsed cycles and form the result.
   function automatic result_type advance_line_timing(input logic [7:0] elapsed);
      result_type  r;
      logic [10:0] sum;
      logic        render;
      render = 1'b0;
      if (shadow_cfg.display_enable) begin
         sum = {1'b0, cycle_tally} + elapsed;
         cycle_tally = (sum > COUNT_MAX) ? COUNT_MAX : sum[9:0];
         case (scan_mode)
            MODE_CODE_OAM: begin
               if (cycle_tally >= OAM_END) scan_mode = MODE_CODE_DRAW;
            end
            MODE_CODE_DRAW: begin
               if (cycle_tally >= DRAW_END) begin
                  scan_mode = MODE_CODE_HBLANK;
                  render = 1'b1;
                  render_pulses++;
               end
            end
            MODE_CODE_HBLANK: begin
               if (cycle_tally >= LINE_END) begin
                  scan_line = scan_line + 8'd1;
                  cycle_tally = '0;
                  scan_mode = (scan_line < FIRST_VBLANK_LINE) ? MODE_CODE_OAM
                                                              : MODE_CODE_VBLANK;
               end
            end
            default: begin
               if (cycle_tally >= LINE_END) begin
                  scan_line = scan_line + 8'd1;
                  cycle_tally = '0;
                  if (scan_line > LAST_LINE) begin
                     scan_line = '0;
                     scan_mode = MODE_CODE_OAM;
                     frame_wraps++;
                  end
               end
            end
         endcase
      end
      r.line_number  = scan_line;
      r.display_mode = scan_mode;
      r.render_line  = render;
      r.status_byte  = {shadow_cfg.status_enables, scan_line == shadow_cfg.line_compare,
                        scan_mode};
      return r;
   endfunction

   // Print one line per mismatch and count them all.
   task automatic flag_mismatch(input string what, input int got_v, input int want_v);
      mismatches++;
      $display("mismatch in %s at result %0d: got %0d, expected %0d",
               what, results_seen, got_v, want_v);
   endtask

   // One register write; the shadow follows once the beat is taken.
   task automatic write_csr(input logic [1:0] index, input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_DISPLAY_ENABLE: shadow_cfg.display_enable = value[0];
         CSR_LINE_COMPARE:   shadow_cfg.line_compare   = value;
         CSR_STATUS_ENABLES: shadow_cfg.status_enables = value[3:0];
         default: ;
      endcase
   endtask

   // Wait until every beat has gone through and the pipeline has settled.
   task automatic wait_for_quiet();
      wait (pending_cycles.size() == 0 && !req_tvalid && expected_timing.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   // Mostly large steps so that lines and frames go by quickly, with some noise.
   task automatic queue_random_cycles(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 10)
            pending_cycles.push_back(8'($urandom_range(255)));
         else if (pick < 75)
            pending_cycles.push_back(8'($urandom_range(255, 120)));
         else if (pick < 90)
            pending_cycles.push_back(8'($urandom_range(119, 1)));
         else
            pending_cycles.push_back(($urandom_range(1) != 0) ? 8'd255 : 8'd0);
      end
   endtask

   // Request driver: holds a beat until it is taken, idles at random.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_timing.push_back(advance_line_timing(req_tdata));
            beats_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_cycles.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_cycles.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here once it is requested.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_trigger != hold_served) begin
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_trigger;
      end
   end

   // Result monitor: compares each beat with the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_beat = result_type'(rsp_tdata[17:0]);
            if (expected_timing.size() == 0) begin
               flag_mismatch("unexpected beat", int'(rsp_tdata), 0);
            end else begin
               want_beat = expected_timing.pop_front();
               if (got_beat.line_number != want_beat.line_number)
                  flag_mismatch("line_number", got_beat.line_number, want_beat.line_number);
               if (got_beat.display_mode != want_beat.display_mode)
                  flag_mismatch("display_mode", got_beat.display_mode,
                                want_beat.display_mode);
               if (got_beat.render_line != want_beat.render_line)
                  flag_mismatch("render_line", got_beat.render_line, want_beat.render_line);
               if (got_beat.status_byte != want_beat.status_byte)
                  flag_mismatch("status_byte", got_beat.status_byte, want_beat.status_byte);
               if (want_beat.display_mode == MODE_CODE_VBLANK) vblank_results++;
               if (want_beat.status_byte[2]) compare_hits++;
            end
            results_seen++;
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles with no beat on any channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("stalled for %0d cycles with %0d results outstanding",
                  idle_cycles, expected_timing.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Display disabled after reset: timing stays frozen.
      pending_cycles.push_back(8'd255);
      pending_cycles.push_back(8'd0);
      wait_for_quiet();

      // Upper register bits and the unused index must be ignored.
      write_csr(CSR_STATUS_ENABLES, 8'hFF);
      write_csr(CSR_LINE_COMPARE, 8'd2);
      write_csr(CSR_UNUSED_INDEX, 8'($urandom_range(255)));
      write_csr(CSR_DISPLAY_ENABLE, 8'hFF);

      // Thresholds hit exactly, then large steps that pass several at once.
      pending_cycles.push_back(8'd0);   pending_cycles.push_back(8'd79);
      pending_cycles.push_back(8'd1);   pending_cycles.push_back(8'd171);
      pending_cycles.push_back(8'd1);   pending_cycles.push_back(8'd203);
      pending_cycles.push_back(8'd1);   pending_cycles.push_back(8'd255);
      pending_cycles.push_back(8'd0);   pending_cycles.push_back(8'd255);
      pending_cycles.push_back(8'd128); pending_cycles.push_back(8'd128);
      pending_cycles.push_back(8'd0);   pending_cycles.push_back(8'd255);

      // Random blocks under three idling patterns and changing settings.
      for (int blk = 0; blk < 6; blk++) begin
         wait_for_quiet();
         send_idle_pct = (blk < 2) ? 8 : (blk < 4) ? 83 : 0;
         recv_idle_pct = (blk < 2) ? 83 : (blk < 4) ? 8 : 0;
         case (blk)
            0: write_csr(CSR_LINE_COMPARE, 8'd144);
            1: write_csr(CSR_LINE_COMPARE, 8'd0);
            2: write_csr(CSR_LINE_COMPARE, 8'd255);
            3: write_csr(CSR_LINE_COMPARE, 8'($urandom_range(153)));
            4: write_csr(CSR_LINE_COMPARE, 8'd153);
            default: write_csr(CSR_LINE_COMPARE, 8'($urandom_range(255)));
         endcase
         case (blk)
            1: write_csr(CSR_STATUS_ENABLES, 8'h0F);
            2: write_csr(CSR_STATUS_ENABLES, 8'h00);
            default: write_csr(CSR_STATUS_ENABLES, 8'($urandom_range(255)));
         endcase
         if (blk == 3) begin
            // A frozen stretch in the middle of a frame.
            write_csr(CSR_DISPLAY_ENABLE, 8'($urandom_range(255)) & 8'hFE);
            queue_random_cycles(30);
            wait_for_quiet();
         end
         write_csr(CSR_DISPLAY_ENABLE, 8'($urandom_range(255)) | 8'h01);
         queue_random_cycles(BLOCK_ITEMS);
         if (blk == 4) hold_trigger++;
      end

      wait_for_quiet();
      repeat (8) @(posedge clock);
      $display("Sent %0d request beats and checked %0d results over %0d frame wraps.",
               beats_sent, results_seen, frame_wraps);
      $display("Saw %0d render pulses, %0d vblank results and %0d compare matches.",
               render_pulses, vblank_results, compare_hits);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
design/lltc_pkg.sv
design/lltc_timing_core.sv
design/lcd_line_timing_controller_unit.sv
bench/lcd_line_timing_controller_unit_tb.sv
